@@ design/copolymer_growth_kmc_step_macros.svh @@
// Assertion macros for the checker file of this block.
`ifndef COPOLYMER_GROWTH_KMC_STEP_MACROS_SVH
`define COPOLYMER_GROWTH_KMC_STEP_MACROS_SVH

// The property holds in the same cycle as its trigger.
`define CGK_ASSERT_NOW(name, trig, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (prop)) \
    else $error("assertion failed");

// The property holds in the cycle after its trigger.
`define CGK_ASSERT_NEXT(name, trig, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error("assertion failed");

`endif

@@ design/cgk_pkg.sv @@
package cgk_pkg;

  localparam int MAX_LEN = 256;
  localparam int TDEPTH  = MAX_LEN + 1;
  localparam int LW      = $clog2(MAX_LEN + 1);
  localparam int PAW     = $clog2(MAX_LEN);
  localparam int TAW     = $clog2(TDEPTH);
  localparam int DW      = 50;
  localparam int QW      = 17;

  localparam logic [QW-1:0] Q_ONE = 17'h10000;
  localparam logic [19:0] C1_WEIGHT = 20'd98304;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic [2:0] TR_NONE   = 3'd0;
  localparam logic [2:0] TR_REMOVE = 3'd5;

  localparam logic [1:0] OUT_NONE   = 2'd0;
  localparam logic [1:0] OUT_ADD    = 2'd1;
  localparam logic [1:0] OUT_REMOVE = 2'd2;

  localparam logic [2:0] REG_ON_RATE  = 3'd0;
  localparam logic [2:0] REG_BB_RATE  = 3'd1;
  localparam logic [2:0] REG_MM_WGT   = 3'd2;
  localparam logic [2:0] REG_BB_WGT   = 3'd3;
  localparam logic [2:0] REG_BIND_WGT = 3'd4;
  localparam logic [2:0] REG_TARGET   = 3'd5;

  // Bases 1 and 2 pair, as do bases 3 and 4; every other combination is a mismatch.
  function automatic logic paired(input logic [2:0] a, input logic [2:0] b);
    logic ok;
    ok = 1'b0;
    case (a)
      3'd1: ok = (b == 3'd2);
      3'd2: ok = (b == 3'd1);
      3'd3: ok = (b == 3'd4);
      3'd4: ok = (b == 3'd3);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

@@ design/cgk_ram.sv @@
module cgk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/copolymer_growth_kmc_step.sv @@
// A load request's result strobes on done_o in the cycle after the request is taken.
// A step request keeps busy high until it is through, and its result strobes in the first
// cycle with busy low again: one shared restoring divider that retires one quotient bit per
// cycle computes up to four choice thresholds and four acceptance quotients, one after
// another, with short memory read and multiply stages around them. A step on a
// finished polymer answers in the next cycle. Every result is shown for exactly one cycle
// and must be taken then, since the receiver cannot stall.
module copolymer_growth_kmc_step
  import cgk_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              op_i,
  input  logic [2:0]        template_base_i,
  input  logic [15:0]       rand_choose_i,
  input  logic [15:0]       rand_accept_i,
  output logic              done_o,
  output logic [LW-1:0]     polymer_length_o,
  output logic [2:0]        transition_o,
  output logic [1:0]        step_outcome_o,
  output logic [LW-1:0]     wrong_count_o,
  output logic              finished_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_RD1    = 5'd1;
  localparam logic [4:0] ST_RD2    = 5'd2;
  localparam logic [4:0] ST_CH_SET = 5'd3;
  localparam logic [4:0] ST_CH_CHK = 5'd4;
  localparam logic [4:0] ST_R0     = 5'd5;
  localparam logic [4:0] ST_R1     = 5'd6;
  localparam logic [4:0] ST_R2     = 5'd7;
  localparam logic [4:0] ST_R3     = 5'd8;
  localparam logic [4:0] ST_R4     = 5'd9;
  localparam logic [4:0] ST_R5     = 5'd10;
  localparam logic [4:0] ST_R6     = 5'd11;
  localparam logic [4:0] ST_FIN    = 5'd12;
  localparam logic [4:0] ST_DIVS   = 5'd13;
  localparam logic [4:0] ST_DIVI   = 5'd14;

  logic [15:0]     k_q, bb_q;
  logic [16:0]     wm_q, wbb_q, wb_q;
  logic [LW-1:0]   tgt_q;
  logic [TAW-1:0]  fill_q;
  logic [LW-1:0]   len_q;
  logic [LW-1:0]   hw_q;
  logic [LW-1:0]   cnt_q;
  logic [4:0]      st_q, ret_q;
  logic [15:0]     rc_q, ra_q;
  logic [2:0]      ti_q, tn_q, pi_q;
  logic [2:0]      kidx_q, trans_q;
  logic [1:0]      outc_q;
  logic            done_q, done_d;
  logic [DW-1:0]   n_q, d_q, r_q, a1_q;
  logic [QW-1:0]   qt_q, beta1_q, gamma2_q;
  logic [3:0]      it_q;
  logic [32:0]     kwb_q, bwb_q;
  logic [33:0]     m1_q, m2_q;

  logic            accept, fin, cfg_we;
  logic            t_we, p_we, push, keep, wrong_new;
  logic            wf_we, wf_rdata, wf_old;
  logic [TAW-1:0]  t_addr;
  logic [PAW-1:0]  p_addr, idx;
  logic [2:0]      t_rdata, p_rdata, p_cur;
  logic [18:0]     s_k, s_all;
  logic [16:0]     w_a;
  logic [DW:0]     r2;
  logic            ge;
  logic [LW-1:0]   len_m1;

  assign accept = start && !busy;
  assign busy   = (st_q != ST_IDLE);
  assign fin    = (len_q >= tgt_q) || (len_q >= LW'(MAX_LEN));
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;
  assign len_m1 = len_q - LW'(1);
  assign idx    = len_m1[PAW-1:0];
  assign p_cur  = (len_q == LW'(1)) ? 3'd1 : p_rdata;
  assign wrong_new = !paired(t_rdata, p_cur);

  assign push = (trans_q != TR_REMOVE) && (qt_q > {1'b0, ra_q});
  assign keep = (trans_q == TR_REMOVE) && (qt_q > {1'b0, ra_q});

  assign done_d = (st_q == ST_FIN) || (accept && (op_i == OP_LOAD || fin));

  assign t_we   = accept && (op_i == OP_LOAD) && (fill_q < TAW'(TDEPTH));
  assign t_addr = t_we ? fill_q : ((st_q == ST_RD1) ? TAW'(len_q) : TAW'(len_m1));
  assign p_we   = (st_q == ST_FIN) && push;
  assign p_addr = p_we ? len_q[PAW-1:0] : idx;

  // Flag entries at or above the high-water mark have never been written and read as clear.
  assign wf_we  = (st_q == ST_RD1);
  assign wf_old = ({1'b0, idx} < hw_q) && wf_rdata;

  cgk_ram #(.WIDTH(3), .DEPTH(TDEPTH)) u_tmpl (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .addr_i  (t_addr),
    .wdata_i (template_base_i),
    .rdata_o (t_rdata)
  );

  cgk_ram #(.WIDTH(3), .DEPTH(MAX_LEN)) u_poly (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .addr_i  (p_addr),
    .wdata_i (trans_q),
    .rdata_o (p_rdata)
  );

  cgk_ram #(.WIDTH(1), .DEPTH(MAX_LEN)) u_flags (
    .clk_i   (clk_i),
    .we_i    (wf_we),
    .addr_i  (idx),
    .wdata_i (wrong_new),
    .rdata_o (wf_rdata)
  );

  always_comb begin
    s_k   = '0;
    s_all = '0;
    for (int b = 1; b <= 4; b++) begin
      s_all = s_all + (paired(tn_q, 3'(b)) ? 19'(Q_ONE) : 19'(wm_q));
      if (3'(b) <= kidx_q) begin
        s_k = s_k + (paired(tn_q, 3'(b)) ? 19'(Q_ONE) : 19'(wm_q));
      end
    end
  end

  always_comb begin
    if (trans_q != TR_REMOVE) begin
      w_a = paired(tn_q, trans_q) ? Q_ONE : wm_q;
    end else begin
      w_a = paired(ti_q, pi_q) ? Q_ONE : wm_q;
    end
  end

  assign r2 = {r_q, 1'b0};
  assign ge = (r2 >= {1'b0, d_q});

  always_comb begin
    case (paddr[4:2])
      REG_ON_RATE:  prdata = {16'd0, k_q};
      REG_BB_RATE:  prdata = {16'd0, bb_q};
      REG_MM_WGT:   prdata = {15'd0, wm_q};
      REG_BB_WGT:   prdata = {15'd0, wbb_q};
      REG_BIND_WGT: prdata = {15'd0, wb_q};
      REG_TARGET:   prdata = {23'd0, tgt_q};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q   <= 16'd256;
      bb_q  <= 16'd256;
      wm_q  <= 17'd65536;
      wbb_q <= 17'd65536;
      wb_q  <= 17'd442;
      tgt_q <= LW'(150);
    end else if (cfg_we) begin
      case (paddr[4:2])
        REG_ON_RATE:  k_q   <= pwdata[15:0];
        REG_BB_RATE:  bb_q  <= pwdata[15:0];
        REG_MM_WGT:   wm_q  <= pwdata[16:0];
        REG_BB_WGT:   wbb_q <= pwdata[16:0];
        REG_BIND_WGT: wb_q  <= pwdata[16:0];
        REG_TARGET:   tgt_q <= pwdata[LW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      ret_q   <= ST_IDLE;
      fill_q  <= '0;
      len_q   <= LW'(1);
      hw_q    <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      trans_q <= TR_NONE;
      outc_q  <= OUT_NONE;
      kidx_q  <= '0;
      it_q    <= '0;
    end else begin
      done_q <= done_d;
      case (st_q)
        ST_IDLE: begin
          if (accept) begin
            if (op_i == OP_LOAD || fin) begin
              if (t_we) begin
                fill_q <= fill_q + TAW'(1);
              end
              trans_q <= TR_NONE;
              outc_q  <= OUT_NONE;
            end else begin
              rc_q <= rand_choose_i;
              ra_q <= rand_accept_i;
              st_q <= ST_RD1;
            end
          end
        end
        ST_RD1: begin
          ti_q <= t_rdata;
          pi_q <= p_cur;
          cnt_q <= cnt_q + LW'(wrong_new) - LW'(wf_old);
          if ({1'b0, idx} >= hw_q) begin
            hw_q <= {1'b0, idx} + LW'(1);
          end
          st_q <= ST_RD2;
        end
        ST_RD2: begin
          tn_q   <= t_rdata;
          kidx_q <= 3'd1;
          if (len_q == LW'(1)) begin
            trans_q <= 3'({1'b0, rc_q[15:14]}) + 3'd1;
            st_q    <= ST_R0;
          end else begin
            st_q <= ST_CH_SET;
          end
        end
        ST_CH_SET: begin
          n_q   <= DW'(k_q * s_k);
          d_q   <= DW'(k_q * (20'(s_all) + C1_WEIGHT));
          ret_q <= ST_CH_CHK;
          st_q  <= ST_DIVS;
        end
        ST_CH_CHK: begin
          if ({1'b0, rc_q} < qt_q) begin
            trans_q <= kidx_q;
            st_q    <= ST_R0;
          end else if (kidx_q == 3'd4) begin
            trans_q <= TR_REMOVE;
            st_q    <= ST_R0;
          end else begin
            kidx_q <= kidx_q + 3'd1;
            st_q   <= ST_CH_SET;
          end
        end
        ST_R0: begin
          kwb_q <= k_q * wb_q;
          bwb_q <= bb_q * wbb_q;
          st_q  <= ST_R1;
        end
        ST_R1: begin
          n_q   <= DW'({bwb_q, 16'd0});
          d_q   <= DW'({bwb_q, 16'd0}) + DW'({kwb_q, 16'd0});
          ret_q <= ST_R2;
          st_q  <= ST_DIVS;
        end
        ST_R2: begin
          beta1_q <= qt_q;
          n_q     <= DW'({kwb_q, 16'd0});
          ret_q   <= ST_R3;
          st_q    <= ST_DIVS;
        end
        ST_R3: begin
          gamma2_q <= qt_q;
          a1_q     <= kwb_q * w_a;
          st_q     <= ST_R4;
        end
        ST_R4: begin
          n_q   <= DW'({bb_q, 32'd0});
          d_q   <= a1_q + DW'({bb_q, 32'd0});
          ret_q <= ST_R5;
          st_q  <= ST_DIVS;
        end
        ST_R5: begin
          m1_q    <= beta1_q * qt_q;
          m2_q    <= qt_q * gamma2_q;
          st_q    <= ST_R6;
        end
        ST_R6: begin
          d_q   <= DW'(34'h1_0000_0000 - m1_q);
          n_q   <= (trans_q != TR_REMOVE) ? DW'(m2_q) : DW'({gamma2_q, 16'd0});
          ret_q <= ST_FIN;
          st_q  <= ST_DIVS;
        end
        ST_FIN: begin
          if (push) begin
            len_q  <= len_q + LW'(1);
            outc_q <= OUT_ADD;
          end else if (trans_q == TR_REMOVE && !keep) begin
            len_q  <= len_m1;
            outc_q <= OUT_REMOVE;
          end else begin
            outc_q <= OUT_NONE;
          end
          st_q <= ST_IDLE;
        end
        ST_DIVS: begin
          if (d_q == '0) begin
            qt_q <= '0;
            st_q <= ret_q;
          end else if (n_q >= d_q) begin
            qt_q <= Q_ONE;
            st_q <= ret_q;
          end else begin
            r_q  <= n_q;
            qt_q <= '0;
            it_q <= '0;
            st_q <= ST_DIVI;
          end
        end
        ST_DIVI: begin
          r_q  <= ge ? DW'(r2 - {1'b0, d_q}) : r2[DW-1:0];
          qt_q <= {qt_q[QW-2:0], ge};
          it_q <= it_q + 4'd1;
          if (it_q == 4'd15) begin
            st_q <= ret_q;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign done_o           = done_q;
  assign polymer_length_o = len_q;
  assign transition_o     = trans_q;
  assign step_outcome_o   = outc_q;
  assign wrong_count_o    = cnt_q;
  assign finished_o       = fin;

endmodule

@@ design/cgk_checker.sv @@
`include "copolymer_growth_kmc_step_macros.svh"

module cgk_checker
  import cgk_pkg::*;
(
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          op_i,
  input logic          done_o,
  input logic [2:0]    transition_o,
  input logic [1:0]    step_outcome_o
);

  logic add_done, remove_done;

  assign add_done    = done_o && step_outcome_o == OUT_ADD;
  assign remove_done = done_o && step_outcome_o == OUT_REMOVE;

  `CGK_ASSERT_NEXT(a_load_answers, start && !busy && op_i == OP_LOAD, done_o)
  `CGK_ASSERT_NOW(a_done_idle, done_o, !busy)
  `CGK_ASSERT_NOW(a_add_has_base, add_done, transition_o >= 3'd1 && transition_o <= 3'd4)
  `CGK_ASSERT_NOW(a_remove_branch, remove_done, transition_o == TR_REMOVE)

endmodule

bind copolymer_growth_kmc_step cgk_checker u_cgk_checker (.*);
